// ----- src/gsa_pkg.sv -----
// Package with the shared codes and default sizes of the generational slot allocator.
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int SLOTS_DEF      = 1024;
    localparam int QUAR_DEPTH_DEF = 64;
    localparam int GEN_BITS_DEF   = 16;
    localparam int OBJ_BITS_DEF   = 32;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_RESOLVE = 2'd2;
    localparam logic [1:0] REQ_HANDLE  = 2'd3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_POOL_FULL  = 3'd1;
    localparam logic [2:0] ST_RANGE      = 3'd2;
    localparam logic [2:0] ST_STALE      = 3'd3;
    localparam logic [2:0] ST_FREE_EMPTY = 3'd4;

    localparam logic [2:0] REG_SLOT_LIMIT = 3'd0;
    localparam logic [2:0] REG_QUAR_LIMIT = 3'd4;

endpackage

// ----- src/generational_slot_allocator_top.sv -----
// Top level of the generational slot allocator with its configuration port.
// Usage: a request is a transfer taken at a rising edge with start high and busy low.
// The allocator handles one request at a time; busy stays high until its result is out.
// Each request gives one result, shown for one cycle while done is high.
// The receiver cannot stall; a result must be taken in its done cycle.
// Allocates with a zero object and out-of-range requests end in the decision state;
// an allocate of a never-used slot ends in the allocate state, and a query or a free
// into a ring with room ends once the slot table has been read. An allocate from the
// free stack pops an index first. A free into a full ring moves the index at the ring
// cursor to the free stack, writes the freed slot in its place and steps the cursor.
// An allocate that spills the quarantine first moves each parked index to the stack.
// Configuration registers sit on the APB port: slot_limit at 0, quarantine_limit at 4.
// Write them only while busy is low.
// Reset empties the pool and sets both limits to their largest values; no clearing
// pass is needed, since table entries at or above the high-water mark read as zero.
`timescale 1ns / 1ps

module generational_slot_allocator_top #(
    parameter int SLOTS      = gsa_pkg::SLOTS_DEF,
    parameter int QUAR_DEPTH = gsa_pkg::QUAR_DEPTH_DEF,
    parameter int GEN_BITS   = gsa_pkg::GEN_BITS_DEF,
    parameter int OBJ_BITS   = gsa_pkg::OBJ_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       req_type,
    input  logic [$clog2(SLOTS)-1:0]         slot_index,
    input  logic [GEN_BITS-1:0]              generation,
    input  logic [OBJ_BITS-1:0]              object_ref,
    output logic                             done,
    output logic [2:0]                       status,
    output logic [$clog2(SLOTS)-1:0]         slot_index_res,
    output logic [GEN_BITS-1:0]              generation_res,
    output logic [OBJ_BITS-1:0]              object_ref_res,
    output logic [$clog2(SLOTS+1)-1:0]       alive_count
);
    import gsa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int QC_W  = $clog2(QUAR_DEPTH + 1);

    logic [CNT_W-1:0] slot_lim;
    logic [QC_W-1:0]  quar_lim;

    gsa_cfg #(
        .SLOTS      (SLOTS),
        .QUAR_DEPTH (QUAR_DEPTH),
        .CNT_W      (CNT_W),
        .QC_W       (QC_W)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .slot_lim (slot_lim),
        .quar_lim (quar_lim)
    );

    gsa_core #(
        .SLOTS      (SLOTS),
        .QUAR_DEPTH (QUAR_DEPTH),
        .GEN_BITS   (GEN_BITS),
        .OBJ_BITS   (OBJ_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W),
        .QC_W       (QC_W)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .slot_lim       (slot_lim),
        .quar_lim       (quar_lim),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .slot_index     (slot_index),
        .generation     (generation),
        .object_ref     (object_ref),
        .done           (done),
        .status         (status),
        .slot_index_res (slot_index_res),
        .generation_res (generation_res),
        .object_ref_res (object_ref_res),
        .alive_count    (alive_count)
    );

endmodule

// ----- src/gsa_ram.sv -----
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module gsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/gsa_cfg.sv -----
// APB configuration registers with the clamped slot and quarantine limits.
`timescale 1ns / 1ps

module gsa_cfg #(
    parameter int SLOTS      = gsa_pkg::SLOTS_DEF,
    parameter int QUAR_DEPTH = gsa_pkg::QUAR_DEPTH_DEF,
    parameter int CNT_W      = $clog2(SLOTS + 1),
    parameter int QC_W       = $clog2(QUAR_DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [CNT_W-1:0] slot_lim,
    output logic [QC_W-1:0]  quar_lim
);
    import gsa_pkg::*;

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [QC_W-1:0]  QD_C    = QC_W'(QUAR_DEPTH);

    logic [CNT_W-1:0] slot_limit_reg;
    logic [QC_W-1:0]  quar_limit_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_limit_reg <= SLOTS_C;
            quar_limit_reg <= QD_C;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_QUAR_LIMIT[2])
            begin
                quar_limit_reg <= pwdata[QC_W-1:0];
            end
            else
            begin
                slot_limit_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_QUAR_LIMIT[2])
        begin
            prdata[QC_W-1:0] = quar_limit_reg;
        end
        else
        begin
            prdata[CNT_W-1:0] = slot_limit_reg;
        end
    end

    always_comb
    begin
        if (slot_limit_reg == '0)
        begin
            slot_lim = CNT_W'(1);
        end
        else if (slot_limit_reg > SLOTS_C)
        begin
            slot_lim = SLOTS_C;
        end
        else
        begin
            slot_lim = slot_limit_reg;
        end
        if (quar_limit_reg == '0)
        begin
            quar_lim = QC_W'(1);
        end
        else if (quar_limit_reg > QD_C)
        begin
            quar_lim = QD_C;
        end
        else
        begin
            quar_lim = quar_limit_reg;
        end
    end

endmodule

// ----- src/gsa_core.sv -----
// Request sequencer with the slot table, free stack and quarantine ring memories.
`timescale 1ns / 1ps

module gsa_core #(
    parameter int SLOTS      = gsa_pkg::SLOTS_DEF,
    parameter int QUAR_DEPTH = gsa_pkg::QUAR_DEPTH_DEF,
    parameter int GEN_BITS   = gsa_pkg::GEN_BITS_DEF,
    parameter int OBJ_BITS   = gsa_pkg::OBJ_BITS_DEF,
    parameter int IDX_W      = $clog2(SLOTS),
    parameter int CNT_W      = $clog2(SLOTS + 1),
    parameter int QC_W       = $clog2(QUAR_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_W-1:0]    slot_lim,
    input  logic [QC_W-1:0]     quar_lim,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          req_type,
    input  logic [IDX_W-1:0]    slot_index,
    input  logic [GEN_BITS-1:0] generation,
    input  logic [OBJ_BITS-1:0] object_ref,
    output logic                done,
    output logic [2:0]          status,
    output logic [IDX_W-1:0]    slot_index_res,
    output logic [GEN_BITS-1:0] generation_res,
    output logic [OBJ_BITS-1:0] object_ref_res,
    output logic [CNT_W-1:0]    alive_count
);
    import gsa_pkg::*;

    localparam int QI_W = (QUAR_DEPTH > 1) ? $clog2(QUAR_DEPTH) : 1;
    localparam int TW   = GEN_BITS + OBJ_BITS;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_ALLOC  = 4'd2;
    localparam logic [3:0] S_SPILL  = 4'd3;
    localparam logic [3:0] S_POP    = 4'd4;
    localparam logic [3:0] S_TUSE   = 4'd5;
    localparam logic [3:0] S_QWR    = 4'd6;
    localparam logic [3:0] S_MOD    = 4'd7;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          req_reg, req_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [GEN_BITS-1:0] hgen_reg, hgen_next;
    logic [OBJ_BITS-1:0] obj_reg, obj_next;
    logic [GEN_BITS-1:0] gsave_reg, gsave_next;
    logic [CNT_W-1:0]    fc_reg, fc_next;
    logic [CNT_W-1:0]    hw_reg, hw_next;
    logic [QC_W-1:0]     qc_reg, qc_next;
    logic [QI_W-1:0]     cur_reg, cur_next;
    logic [QC_W-1:0]     sp_reg, sp_next;
    logic                pend_reg, pend_next;
    logic [QC_W-1:0]     mod_reg, mod_next;

    logic                done_reg, done_next;
    logic [2:0]          status_reg, status_next;
    logic [IDX_W-1:0]    sidx_reg, sidx_next;
    logic [GEN_BITS-1:0] gres_reg, gres_next;
    logic [OBJ_BITS-1:0] ores_reg, ores_next;

    logic                tab_we;
    logic [IDX_W-1:0]    tab_waddr, tab_raddr;
    logic [TW-1:0]       tab_wdata, tab_rdata;
    logic                fs_we;
    logic [IDX_W-1:0]    fs_waddr, fs_raddr;
    logic [IDX_W-1:0]    fs_wdata, fs_rdata;
    logic                qr_we;
    logic [QI_W-1:0]     qr_waddr, qr_raddr;
    logic [IDX_W-1:0]    qr_wdata, qr_rdata;

    logic [CNT_W-1:0]    fc_dec;
    logic                ent_valid;
    logic [GEN_BITS-1:0] rgen, ngen;
    logic [OBJ_BITS-1:0] robj;

    gsa_ram #(.WIDTH(TW), .DEPTH(SLOTS), .AW(IDX_W)) u_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    gsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS), .AW(IDX_W)) u_fstk (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    gsa_ram #(.WIDTH(IDX_W), .DEPTH(QUAR_DEPTH), .AW(QI_W)) u_ring (
        .clk   (clk),
        .we    (qr_we),
        .waddr (qr_waddr),
        .wdata (qr_wdata),
        .raddr (qr_raddr),
        .rdata (qr_rdata)
    );

    assign fc_dec    = fc_reg - CNT_W'(1);
    assign ent_valid = CNT_W'(slot_reg) < hw_reg;
    assign rgen      = ent_valid ? tab_rdata[TW-1:OBJ_BITS] : '0;
    assign robj      = ent_valid ? tab_rdata[OBJ_BITS-1:0] : '0;
    assign ngen      = rgen + GEN_BITS'(1);

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign slot_index_res = sidx_reg;
    assign generation_res = gres_reg;
    assign object_ref_res = ores_reg;
    assign alive_count    = (hw_reg >= fc_reg) ? (hw_reg - fc_reg) : '0;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        slot_next   = slot_reg;
        hgen_next   = hgen_reg;
        obj_next    = obj_reg;
        gsave_next  = gsave_reg;
        fc_next     = fc_reg;
        hw_next     = hw_reg;
        qc_next     = qc_reg;
        cur_next    = cur_reg;
        sp_next     = sp_reg;
        pend_next   = pend_reg;
        mod_next    = mod_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        sidx_next   = sidx_reg;
        gres_next   = gres_reg;
        ores_next   = ores_reg;
        tab_we      = 1'b0;
        tab_waddr   = slot_reg;
        tab_wdata   = '0;
        tab_raddr   = slot_reg;
        fs_we       = 1'b0;
        fs_waddr    = fc_reg[IDX_W-1:0];
        fs_wdata    = qr_rdata;
        fs_raddr    = fc_dec[IDX_W-1:0];
        qr_we       = 1'b0;
        qr_waddr    = cur_reg;
        qr_wdata    = slot_reg;
        qr_raddr    = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    slot_next  = slot_index;
                    hgen_next  = generation;
                    obj_next   = object_ref;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                tab_raddr = slot_reg;
                if (req_reg == REQ_ALLOC)
                begin
                    if (obj_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_STALE;
                        sidx_next   = '0;
                        gres_next   = '0;
                        ores_next   = '0;
                        state_next  = S_IDLE;
                    end
                    else if (fc_reg == '0 && qc_reg != '0 && hw_reg >= slot_lim)
                    begin
                        sp_next    = '0;
                        pend_next  = 1'b0;
                        state_next = S_SPILL;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
                else if (CNT_W'(slot_reg) >= slot_lim)
                begin
                    done_next   = 1'b1;
                    status_next = ST_RANGE;
                    sidx_next   = slot_reg;
                    gres_next   = '0;
                    ores_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_TUSE;
                end
            end
            S_SPILL:
            begin
                qr_raddr = sp_reg[QI_W-1:0];
                if (pend_reg && fc_reg < SLOTS_C)
                begin
                    fs_we   = 1'b1;
                    fc_next = fc_reg + CNT_W'(1);
                end
                if (sp_reg < qc_reg)
                begin
                    sp_next   = sp_reg + QC_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        qc_next    = '0;
                        cur_next   = '0;
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC:
            begin
                if (fc_reg != '0)
                begin
                    fc_next    = fc_dec;
                    state_next = S_POP;
                end
                else if (hw_reg < slot_lim)
                begin
                    tab_we      = 1'b1;
                    tab_waddr   = hw_reg[IDX_W-1:0];
                    tab_wdata   = {GEN_BITS'(1), obj_reg};
                    hw_next     = hw_reg + CNT_W'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    sidx_next   = hw_reg[IDX_W-1:0];
                    gres_next   = GEN_BITS'(1);
                    ores_next   = obj_reg;
                    state_next  = S_IDLE;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_POOL_FULL;
                    sidx_next   = '0;
                    gres_next   = '0;
                    ores_next   = '0;
                    state_next  = S_IDLE;
                end
            end
            S_POP:
            begin
                slot_next  = fs_rdata;
                tab_raddr  = fs_rdata;
                state_next = S_TUSE;
            end
            S_TUSE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                sidx_next  = slot_reg;
                unique case (req_reg)
                    REQ_ALLOC:
                    begin
                        tab_we      = 1'b1;
                        tab_wdata   = {ngen, obj_reg};
                        status_next = ST_OK;
                        gres_next   = ngen;
                        ores_next   = obj_reg;
                    end
                    REQ_FREE:
                    begin
                        if (robj == '0)
                        begin
                            status_next = ST_FREE_EMPTY;
                            gres_next   = rgen;
                            ores_next   = '0;
                        end
                        else
                        begin
                            tab_we      = 1'b1;
                            tab_wdata   = {ngen, {OBJ_BITS{1'b0}}};
                            status_next = ST_OK;
                            gres_next   = ngen;
                            ores_next   = '0;
                            gsave_next  = ngen;
                            if (qc_reg < quar_lim)
                            begin
                                qr_we    = 1'b1;
                                qr_waddr = qc_reg[QI_W-1:0];
                                qc_next  = qc_reg + QC_W'(1);
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_QWR;
                            end
                        end
                    end
                    REQ_RESOLVE:
                    begin
                        gres_next = rgen;
                        if (robj != '0 && rgen == hgen_reg)
                        begin
                            status_next = ST_OK;
                            ores_next   = robj;
                        end
                        else
                        begin
                            status_next = ST_STALE;
                            ores_next   = '0;
                        end
                    end
                    REQ_HANDLE:
                    begin
                        gres_next = rgen;
                        if (robj != '0)
                        begin
                            status_next = ST_OK;
                            ores_next   = robj;
                        end
                        else
                        begin
                            status_next = ST_STALE;
                            ores_next   = '0;
                        end
                    end
                    default:
                    begin
                        status_next = ST_STALE;
                    end
                endcase
            end
            S_QWR:
            begin
                if (fc_reg < SLOTS_C)
                begin
                    fs_we   = 1'b1;
                    fc_next = fc_reg + CNT_W'(1);
                end
                qr_we      = 1'b1;
                mod_next   = QC_W'(cur_reg) + QC_W'(1);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (mod_reg >= quar_lim)
                begin
                    mod_next = mod_reg - quar_lim;
                end
                else
                begin
                    cur_next    = mod_reg[QI_W-1:0];
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    sidx_next   = slot_reg;
                    gres_next   = gsave_reg;
                    ores_next   = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fc_reg    <= '0;
            hw_reg    <= '0;
            qc_reg    <= '0;
            cur_reg   <= '0;
            sp_reg    <= '0;
            pend_reg  <= 1'b0;
            mod_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            hw_reg    <= hw_next;
            qc_reg    <= qc_next;
            cur_reg   <= cur_next;
            sp_reg    <= sp_next;
            pend_reg  <= pend_next;
            mod_reg   <= mod_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        slot_reg   <= slot_next;
        hgen_reg   <= hgen_next;
        obj_reg    <= obj_next;
        gsave_reg  <= gsave_next;
        status_reg <= status_next;
        sidx_reg   <= sidx_next;
        gres_reg   <= gres_next;
        ores_reg   <= ores_next;
    end

endmodule

// ----- src/gsa_check.sv -----
// Port-level checker for the generational slot allocator and its bind.
`timescale 1ns / 1ps

module gsa_check #(
    parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
    parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [2:0]                 status,
    input logic [$clog2(SLOTS)-1:0]   slot_index_res,
    input logic [GEN_BITS-1:0]        generation_res,
    input logic [$clog2(SLOTS+1)-1:0] alive_count
);
    import gsa_pkg::*;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result transfer while the allocator is still busy.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("Accepted request did not make the allocator busy.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe lasted more than one cycle.");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_POOL_FULL |-> slot_index_res == '0 && generation_res == '0)
        else $error("Pool-full result carries a slot.");

    a_alive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> alive_count <= ($clog2(SLOTS + 1))'(SLOTS))
        else $error("Live slot count exceeds the table size.");

endmodule

bind generational_slot_allocator_top gsa_check #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
) u_gsa_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .slot_index_res (slot_index_res),
    .generation_res (generation_res),
    .alive_count    (alive_count)
);
